FILE: src/slr_pkg.sv
package slr_pkg;

    // coordinate and error-term widths of the walker
    localparam int COORD_W = 10;
    localparam int ERR_W   = 20;
    localparam int STEP_W  = 8;

    // configuration register indexes
    localparam logic [1:0] CFG_COLOR  = 2'd0;
    localparam logic [1:0] CFG_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_HEIGHT = 2'd2;

    // line kinds
    localparam logic [1:0] KIND_HORIZ = 2'd0;
    localparam logic [1:0] KIND_VERT  = 2'd1;
    localparam logic [1:0] KIND_BRES  = 2'd2;

    // classified line command handed from front to walker
    typedef struct packed {
        logic [1:0]                kind;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [ERR_W-1:0]   d;
        logic signed [ERR_W-1:0]   d_up;
        logic signed [ERR_W-1:0]   d_flat;
        logic [STEP_W-1:0]         steps;
    } t_cmd;

endpackage

FILE: src/slr_front.sv
module slr_front import slr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_data,
    output logic        o_cmd_valid,
    output t_cmd        o_cmd,
    input  logic        i_cmd_pop
);

    logic signed [7:0]       x0, y0, x1, y1;
    logic signed [8:0]       dx, dy;
    logic signed [ERR_W-1:0] dx_e, dy_e, d_diff;
    logic                    horiz, vert, keep, push;
    t_cmd                    cmd;

    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    // field unpack and endpoint deltas
    assign x0 = i_data[7:0];
    assign y0 = i_data[15:8];
    assign x1 = i_data[23:16];
    assign y1 = i_data[31:24];
    assign dx = {x1[7], x1} - {x0[7], x0};
    assign dy = {y1[7], y1} - {y0[7], y0};
    assign dx_e = {{(ERR_W-9){dx[8]}}, dx};
    assign dy_e = {{(ERR_W-9){dy[8]}}, dy};
    assign d_diff = dy_e - dx_e;

    // classify: reversed horizontal or vertical lines draw nothing and are dropped
    assign horiz = (y0 == y1);
    assign vert  = !horiz && (x0 == x1);
    assign keep  = horiz ? !dx[8] : (vert ? !dy[8] : 1'b1);

    always_comb begin
        cmd.x      = {{(COORD_W-8){x0[7]}}, x0};
        cmd.y      = {{(COORD_W-8){y0[7]}}, y0};
        cmd.d      = {dy_e[ERR_W-2:0], 1'b0} - dx_e;
        cmd.d_up   = {d_diff[ERR_W-2:0], 1'b0};
        cmd.d_flat = {dy_e[ERR_W-2:0], 1'b0};
        if (horiz) begin
            cmd.kind  = KIND_HORIZ;
            cmd.steps = dx[7:0];
        end else if (vert) begin
            cmd.kind  = KIND_VERT;
            cmd.steps = dy[7:0];
        end else begin
            cmd.kind  = KIND_BRES;
            cmd.steps = dx[8] ? '0 : dx[7:0];
        end
    end

    // two-entry command queue
    assign o_ready     = (r_cnt != 2'd2);
    assign push        = i_valid && o_ready && keep;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= !r_wp;
            end
            if (i_cmd_pop) begin
                r_rp <= !r_rp;
            end
            case ({push, i_cmd_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

FILE: src/slr_walker.sv
module slr_walker import slr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cmd_valid,
    input  t_cmd        i_cmd,
    output logic        o_cmd_pop,
    input  logic [6:0]  i_width,
    input  logic [6:0]  i_height,
    input  logic [7:0]  i_color,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [11:0] o_index,
    output logic [7:0]  o_color,
    output logic        o_last
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_WALK  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [1:0]                r_state;
    logic [1:0]                r_kind;
    logic signed [COORD_W-1:0] r_x, r_y;
    logic signed [ERR_W-1:0]   r_d, r_d_up, r_d_flat;
    logic [STEP_W-1:0]         r_left;
    logic                      r_pend_v;
    logic [11:0]               r_pend_idx;
    logic                      r_out_v;
    logic [11:0]               r_out_idx;
    logic [7:0]                r_out_color;
    logic                      r_out_last;

    logic        on_disp, out_free, adv, load_out;
    logic [6:0]  x_off;
    logic [12:0] row_base;
    logic [11:0] cand_idx;

    // candidate pixel: display test and serpentine index
    assign on_disp = !r_x[COORD_W-1] && !r_y[COORD_W-1]
                     && (r_x < $signed({{(COORD_W-7){1'b0}}, i_width}))
                     && (r_y < $signed({{(COORD_W-7){1'b0}}, i_height}));
    assign x_off    = r_y[0] ? (i_width - 7'd1 - {1'b0, r_x[5:0]}) : {1'b0, r_x[5:0]};
    assign row_base = {7'd0, r_y[5:0]} * {6'd0, i_width};
    assign cand_idx = 12'(row_base + {6'd0, x_off});

    // the pending pixel is held until the next one proves it is not the last
    assign out_free  = !r_out_v || i_ready;
    assign adv       = !on_disp || !r_pend_v || out_free;
    assign o_cmd_pop = (r_state == ST_IDLE) && i_cmd_valid;
    assign load_out  = ((r_state == ST_WALK) && adv && on_disp && r_pend_v)
                       || ((r_state == ST_FLUSH) && r_pend_v && out_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (load_out) begin
                r_out_v <= 1'b1;
            end else if (i_ready) begin
                r_out_v <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_cmd_valid) begin
                        r_state <= ST_WALK;
                    end
                end
                ST_WALK: begin
                    if (adv) begin
                        if (on_disp) begin
                            r_pend_v <= 1'b1;
                        end
                        if (r_left == '0) begin
                            r_state <= ST_FLUSH;
                        end
                    end
                end
                ST_FLUSH: begin
                    if (!r_pend_v) begin
                        r_state <= ST_IDLE;
                    end else if (out_free) begin
                        r_pend_v <= 1'b0;
                        r_state  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // walk datapath and output register payload
    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_kind   <= i_cmd.kind;
            r_x      <= i_cmd.x;
            r_y      <= i_cmd.y;
            r_d      <= i_cmd.d;
            r_d_up   <= i_cmd.d_up;
            r_d_flat <= i_cmd.d_flat;
            r_left   <= i_cmd.steps;
        end else if (r_state == ST_WALK && adv) begin
            r_left <= r_left - STEP_W'(1);
            unique case (r_kind)
                KIND_VERT: r_y <= r_y + COORD_W'(1);
                KIND_BRES: begin
                    r_x <= r_x + COORD_W'(1);
                    if (!r_d[ERR_W-1] && (r_d != '0)) begin
                        r_y <= r_y + COORD_W'(1);
                        r_d <= r_d + r_d_up;
                    end else begin
                        r_d <= r_d + r_d_flat;
                    end
                end
                default: r_x <= r_x + COORD_W'(1);
            endcase
        end

        if (r_state == ST_WALK && adv && on_disp) begin
            r_pend_idx <= cand_idx;
            if (r_pend_v) begin
                r_out_idx   <= r_pend_idx;
                r_out_color <= i_color;
                r_out_last  <= 1'b0;
            end
        end else if (r_state == ST_FLUSH && r_pend_v && out_free) begin
            r_out_idx   <= r_pend_idx;
            r_out_color <= i_color;
            r_out_last  <= 1'b1;
        end
    end

    assign o_valid = r_out_v;
    assign o_index = r_out_idx;
    assign o_color = r_out_color;
    assign o_last  = r_out_last;

endmodule

FILE: src/serpentine_line_rasterizer_unit.sv
// channel   direction  transaction                  payload
// s_axis    in         one line command             tdata: start_x, start_y, end_x, end_y
// m_axis    out        one lit pixel                tdata: led_index, color_out; tlast
// cfg       in         one register write           index, data
//
// A command walks one candidate pixel per cycle unless stalled: end - start + 1
// candidates for a horizontal or vertical line, end_x - start_x + 1 (or one when
// reversed) for a sloped one, plus a load step in IDLE and a flush step in FLUSH.
// Reversed horizontal or vertical commands are dropped at the queue input.
// The walker stalls only when a displayed pixel needs the output register.
// A two-entry command queue takes new commands while the walker is busy.
// Synchronous active-low reset; registers reset to color 0, 32 x 32 display.
module serpentine_line_rasterizer_unit import slr_pkg::*; #(
    parameter int MAX_DIM = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // start_x, start_y, end_x, end_y
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // led_index[11:0], color_out[19:12], zero
    output logic        m_axis_tlast,   // last_pixel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    logic [7:0] r_color;
    logic [6:0] r_width, r_height;
    logic [6:0] width_eff, height_eff;
    logic       cmd_valid, cmd_pop;
    t_cmd       cmd;
    logic [11:0] px_index;
    logic [7:0]  px_color;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color  <= 8'd0;
            r_width  <= 7'd32;
            r_height <= 7'd32;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_COLOR:  r_color  <= i_cfg_data;
                CFG_WIDTH:  r_width  <= i_cfg_data[6:0];
                CFG_HEIGHT: r_height <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // clamp dimensions to 1..MAX_DIM
    assign width_eff  = (r_width == 7'd0) ? 7'd1 :
                        (r_width > 7'(MAX_DIM)) ? 7'(MAX_DIM) : r_width;
    assign height_eff = (r_height == 7'd0) ? 7'd1 :
                        (r_height > 7'(MAX_DIM)) ? 7'(MAX_DIM) : r_height;

    slr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_data      (s_axis_tdata),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    slr_walker u_walker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .i_width     (width_eff),
        .i_height    (height_eff),
        .i_color     (r_color),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_index     (px_index),
        .o_color     (px_color),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {4'd0, px_color, px_index};

endmodule

FILE: src/slr_checker.sv
module slr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready
);

    // a stalled pixel holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled pixel changed");

    // no pixel right after reset
    a_rst_idle: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !m_axis_tvalid)
        else $error("pixel valid after reset");

    // pad bits of the pixel word stay zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[23:20] == 4'd0))
        else $error("pixel pad bits set");

    // the command queue and the config port are ready right after reset
    a_rdy_rst: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> s_axis_tready && o_cfg_ready)
        else $error("not ready after reset");

endmodule

bind serpentine_line_rasterizer_unit slr_checker u_slr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .i_cfg_valid   (i_cfg_valid),
    .o_cfg_ready   (o_cfg_ready)
);

FILE: tb/testbench.sv
module testbench;
    import slr_pkg::*;

    localparam int MAX_DIM        = 64;
    localparam int SETTLE_CYCLES  = 900;   // lets up to three queued commands finish walking
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 5000;

    // one lit pixel as seen on the output stream
    typedef struct {
        logic [11:0] led_index;
        logic [7:0]  color;
        logic        last;
    } t_pixel;

    // tracks the register copy and the pixels still owed by the block
    class line_pixel_scoreboard;
        t_pixel     lit_pixels[$];
        logic [7:0] color;
        logic [6:0] width;
        logic [6:0] height;
        int         errors;

        function new();
            color  = 8'd0;
            width  = 7'd32;
            height = 7'd32;
            errors = 0;
        endfunction

        function int clamp_dim(logic [6:0] v);
            if (v == 0) return 1;
            if (v > MAX_DIM) return MAX_DIM;
            return int'(v);
        endfunction

        function void set_reg(logic [1:0] idx, logic [7:0] val);
            case (idx)
                CFG_COLOR:  color  = val;
                CFG_WIDTH:  width  = val[6:0];
                CFG_HEIGHT: height = val[6:0];
                default: ;
            endcase
        endfunction

        // queue a pixel if it falls on the display, serpentine order on odd rows
        function void plot(int x, int y, inout int n);
            int     w;
            int     h;
            int     idx;
            t_pixel p;
            w = clamp_dim(width);
            h = clamp_dim(height);
            if (x < 0 || x >= w || y < 0 || y >= h || n >= MAX_DIM) return;
            idx = y * w + (((y % 2) == 0) ? x : (w - 1 - x));
            p.led_index = idx[11:0];
            p.color     = color;
            p.last      = 1'b0;
            lit_pixels.push_back(p);
            n++;
        endfunction

        // accepted line command: walk it and record the pixels it lights
        function void trace_line(logic [31:0] cmd);
            int x0;
            int y0;
            int x1;
            int y1;
            int dx;
            int dy;
            int d;
            int y;
            int i;
            int n;
            x0 = $signed(cmd[7:0]);
            y0 = $signed(cmd[15:8]);
            x1 = $signed(cmd[23:16]);
            y1 = $signed(cmd[31:24]);
            n  = 0;
            if (y0 == y1) begin
                for (i = x0; i <= x1; i++) plot(i, y0, n);
            end else if (x0 == x1) begin
                for (i = y0; i <= y1; i++) plot(x0, i, n);
            end else begin
                dx = x1 - x0;
                dy = y1 - y0;
                d  = 2 * dy - dx;
                y  = y0;
                plot(x0, y0, n);
                for (i = x0 + 1; i <= x1; i++) begin
                    if (d > 0) begin
                        y++;
                        d += 2 * dy - 2 * dx;
                    end else begin
                        d += 2 * dy;
                    end
                    plot(i, y, n);
                end
            end
            if (n > 0) lit_pixels[lit_pixels.size() - 1].last = 1'b1;
        endfunction

        function void check_pixel(logic [11:0] led_index, logic [7:0] color_out, logic last);
            t_pixel e;
            if (lit_pixels.size() == 0) begin
                $error("unexpected pixel: led_index %0d color_out %0d last_pixel %0d",
                       led_index, color_out, last);
                errors++;
                return;
            end
            e = lit_pixels.pop_front();
            if (led_index !== e.led_index) begin
                $error("led_index: expected %0d actual %0d", e.led_index, led_index);
                errors++;
            end
            if (color_out !== e.color) begin
                $error("color_out: expected %0d actual %0d", e.color, color_out);
                errors++;
            end
            if (last !== e.last) begin
                $error("last_pixel: expected %0d actual %0d", e.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return lit_pixels.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [7:0]  i_cfg_data;

    line_pixel_scoreboard sb = new();

    int send_idle_pct;
    int recv_idle_pct;
    int hold_left;
    int quiet_cycles;

    serpentine_line_rasterizer_unit #(
        .MAX_DIM(MAX_DIM)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [7:0] sat8(int v);
        if (v > 127) return 8'h7f;
        if (v < -128) return 8'h80;
        return v[7:0];
    endfunction

    // offer one line command; valid stays high into the next call
    task automatic send_line(input int x0, input int y0, input int x1, input int y1);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {sat8(y1), sat8(x1), sat8(y0), sat8(x0)};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // stop offering, wait for all owed pixels, then let queued dark commands finish
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [7:0] color, input logic [7:0] width,
                                input logic [7:0] height);
        logic [1:0] idx [3];
        logic [7:0] val [3];
        idx = '{CFG_COLOR, CFG_WIDTH, CFG_HEIGHT};
        val = '{color, width, height};
        for (int k = 0; k < 3; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= val[k];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // mostly well-formed lines near the display, some noise and reversed endpoints
    task automatic run_random(input int count);
        int w;
        int h;
        int x0;
        int y0;
        int x1;
        int y1;
        int pick;
        w = sb.clamp_dim(sb.width);
        h = sb.clamp_dim(sb.height);
        repeat (count) begin
            pick = $urandom_range(99);
            x0 = int'($urandom_range(w + 7)) - 4;
            y0 = int'($urandom_range(h + 7)) - 4;
            if (pick < 10) begin
                x0 = int'($urandom_range(255)) - 128;
                y0 = int'($urandom_range(255)) - 128;
                x1 = int'($urandom_range(255)) - 128;
                y1 = int'($urandom_range(255)) - 128;
            end else if (pick < 35) begin
                y1 = y0;
                x1 = x0 + int'($urandom_range(w + 4));
            end else if (pick < 55) begin
                x1 = x0;
                y1 = y0 + int'($urandom_range(h + 4));
            end else if (pick < 90) begin
                x1 = x0 + 1 + int'($urandom_range(w + 4));
                y1 = int'($urandom_range(h + 7)) - 4;
            end else begin
                x1 = x0 - int'($urandom_range(8));
                y1 = y0 - int'($urandom_range(8));
            end
            send_line(x0, y0, x1, y1);
        end
    endtask

    // receiver: random stalls, plus a long hold-off on request
    initial begin
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // monitor: note accepted transactions and watch for a stuck run
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) sb.set_reg(i_cfg_index, i_cfg_data);
            if (s_axis_tvalid && s_axis_tready) sb.trace_line(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_pixel(m_axis_tdata[11:0], m_axis_tdata[19:12], m_axis_tlast);
        end
        if (!i_rst_n || (i_cfg_valid && o_cfg_ready) || (s_axis_tvalid && s_axis_tready)
            || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("serpentine_line_rasterizer_unit verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= CFG_COLOR;
        i_cfg_data    <= '0;
        quiet_cycles  <= 0;
        hold_left     = 0;
        send_idle_pct = 13;
        recv_idle_pct = 69;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: 32 x 32, color 0
        send_line(0, 0, 0, 0);            // single point
        send_line(0, 0, 31, 0);           // full even row
        send_line(-128, 1, 127, 1);       // odd row, clipped both ends
        send_line(5, -128, 5, 127);       // column, clipped both ends
        send_line(10, 3, 2, 3);           // reversed horizontal: nothing
        send_line(4, 9, 4, 2);            // reversed vertical: nothing
        send_line(7, 8, 3, 20);           // reversed sloped: start point only
        send_line(0, 0, 20, 7);           // shallow rise
        send_line(0, 0, 10, 30);          // steep: y still rises at most one per step
        send_line(0, 20, 15, 2);          // falling: y never falls
        send_line(100, 100, 120, 120);    // fully off display
        send_line(127, -128, -128, 127);  // field extremes
        drain();

        // largest display
        write_config(8'hff, 8'd64, 8'd64);
        send_line(0, 63, 63, 63);
        send_line(63, 0, 63, 63);
        send_line(-128, -128, 127, 127);  // diagonal, most pixels per line
        send_line(-1, -1, -1, -1);
        drain();

        // zero dimensions act as a single pixel
        write_config(8'h5a, 8'd0, 8'd0);
        send_line(0, 0, 0, 0);
        send_line(-3, 0, 5, 0);
        send_line(0, -5, 0, 5);
        drain();

        write_config(8'h3c, 8'd7, 8'd13);
        run_random(50);
        drain();

        // oversize dimensions clamp to the maximum
        send_idle_pct = 69;
        recv_idle_pct = 13;
        write_config(8'ha5, 8'd200, 8'd65);
        run_random(50);
        drain();

        // no idling; receiver holds off so the command queue backs up
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_config(8'h00, 8'd33, 8'd64);
        hold_left = HOLD_CYCLES;
        run_random(50);
        drain();

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("serpentine_line_rasterizer_unit verification clean");
        end else begin
            $display("serpentine_line_rasterizer_unit verification failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
src/slr_pkg.sv
src/slr_front.sv
src/slr_walker.sv
src/serpentine_line_rasterizer_unit.sv
src/slr_checker.sv
tb/testbench.sv
